/* rtl/sbpe_pkg.sv */
// Shared types and constants of the sieve / binomial prime exponent unit.
// No dependencies; every other file but sbpe_ram imports this package.
`timescale 1ns / 1ps

package sbpe_pkg;

    localparam int NUM_W = 12;   // number_in, total_a, choose_b
    localparam int IDX_W = 10;   // prime_index
    localparam int EXP_W = 4;    // exponent
    localparam int ST_W  = 2;    // status
    localparam int CFG_W = 1;    // config register index

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_SEQ_ERR = 2'd1;
    localparam logic [ST_W-1:0] ST_ABOVE_A = 2'd2;
    localparam logic [ST_W-1:0] ST_B_ABOVE = 2'd3;

    localparam logic [CFG_W-1:0] CFG_TOTAL_A  = 1'b0;
    localparam logic [CFG_W-1:0] CFG_CHOOSE_B = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_LIST_RD,
        S_LIST_CHK,
        S_LIST_DIV,
        S_LIST_END,
        S_LEG,
        S_LEG_DIV,
        S_DONE
    } t_state;

endpackage

/* rtl/sbpe_in_if.sv */
// Request channel carrying the next number to sieve.
// Depends on sbpe_pkg.
`timescale 1ns / 1ps

interface sbpe_in_if
    import sbpe_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] number_in;

    modport source (output valid, output number_in, input ready);
    modport sink   (input valid, input number_in, output ready);
endinterface

/* rtl/sbpe_out_if.sv */
// Result channel: prime flag, list index, binomial exponent and status.
// Depends on sbpe_pkg.
`timescale 1ns / 1ps

interface sbpe_out_if
    import sbpe_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             is_prime;
    logic [IDX_W-1:0] prime_index;
    logic [EXP_W-1:0] exponent;
    logic [ST_W-1:0]  status;

    modport source (output valid, output is_prime, output prime_index,
                    output exponent, output status, input ready);
    modport sink   (input valid, input is_prime, input prime_index,
                    input exponent, input status, output ready);
endinterface

/* rtl/sbpe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sbpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/sbpe_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on sbpe_pkg.
`timescale 1ns / 1ps

module sbpe_div
    import sbpe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [NUM_W-1:0] i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot,
    output logic [NUM_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [NUM_W-1:0] r_dvs, n_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [NUM_W:0]   w_sh;
    logic [NUM_W:0]   w_diff;
    logic             w_ge;

    assign w_sh   = {r_rem, r_quo[NUM_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_dvs};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
            n_cnt  = CNT_W'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[NUM_W-1:0] : w_sh[NUM_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;
endmodule

/* rtl/sieve_binomial_prime_exponents_unit.sv */
// Linear sieve with Legendre exponents of C(total_a, choose_b), top level.
// Depends on sbpe_pkg, sbpe_in_if, sbpe_out_if, sbpe_ram, sbpe_div.
`timescale 1ns / 1ps

// Takes 2, 3, 4, ... one request at a time and reports for each whether it is
// prime, its place in the prime list, and for a prime p the power of p in
// C(total_a, choose_b). After reset the composite bitmap is swept clear, and
// meanwhile no request is taken (config writes still are). Each number then
// passes setup, then one serial division by the shared divider per stored
// prime walked by the sieve, then for a prime p one division per nonzero term
// of the three Legendre sums (roughly 3*log_p(total_a) of them).
// Out-of-sequence or above-limit numbers go from accept straight to S_DONE.
// The shared divider sets the pace. The user must write config only while
// idle; the block itself does not enforce it.
module sieve_binomial_prime_exponents_unit
    import sbpe_pkg::*;
#(
    parameter int MAX_N      = 4096,
    parameter int MAX_PRIMES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_idx,
    input  logic [NUM_W-1:0]  i_cfg_data,
    sbpe_in_if.sink           i_in,
    sbpe_out_if.source        o_out
);
    localparam int CW = $clog2(MAX_N);
    localparam int PW = $clog2(MAX_PRIMES);
    localparam logic [PW:0] CNT_FULL = (PW+1)'(MAX_PRIMES);
    localparam logic [CW-1:0] CLR_LAST = CW'(MAX_N - 1);

    t_state           r_state, n_state;
    logic [NUM_W-1:0] r_total_a, r_choose_b;
    logic [NUM_W-1:0] r_next_exp, n_next_exp;
    logic [PW:0]      r_count, n_count;
    logic [CW-1:0]    r_clr, n_clr;
    logic [NUM_W-1:0] r_num, n_num;
    logic [PW:0]      r_j, n_j;
    logic [1:0]       r_term, n_term;
    logic [NUM_W-1:0] r_x, n_x;
    logic             r_prime, n_prime;
    logic [IDX_W-1:0] r_index, n_index;
    logic [EXP_W-1:0] r_acc, n_acc;
    logic [ST_W-1:0]  r_st, n_st;
    logic             r_out_valid, n_out_valid;
    logic             r_o_prime;
    logic [IDX_W-1:0] r_o_index;
    logic [EXP_W-1:0] r_o_exp;
    logic [ST_W-1:0]  r_o_st;

    logic             w_accept;
    logic             w_cm_we, w_cm_wdata, w_cm_rdata;
    logic [CW-1:0]    w_cm_waddr, w_cm_raddr;
    logic             w_pl_we;
    logic [NUM_W-1:0] w_pl_rdata;
    logic             w_div_start, w_div_done;
    logic [NUM_W-1:0] w_div_a, w_div_b, w_quot, w_rem;
    logic [2*NUM_W-1:0] w_prod;

    sbpe_ram #(.WIDTH(1), .DEPTH(MAX_N)) u_comp_map (
        .i_clk   (i_clk),
        .i_we    (w_cm_we),
        .i_waddr (w_cm_waddr),
        .i_wdata (w_cm_wdata),
        .i_raddr (w_cm_raddr),
        .o_rdata (w_cm_rdata)
    );

    sbpe_ram #(.WIDTH(NUM_W), .DEPTH(MAX_PRIMES)) u_prime_list (
        .i_clk   (i_clk),
        .i_we    (w_pl_we),
        .i_waddr (r_count[PW-1:0]),
        .i_wdata (r_num),
        .i_raddr (r_j[PW-1:0]),
        .o_rdata (w_pl_rdata)
    );

    sbpe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_cm_raddr = CW'(i_in.number_in);
    assign w_prod     = {{NUM_W{1'b0}}, w_pl_rdata} * {{NUM_W{1'b0}}, r_num};

    always_comb begin
        n_state     = r_state;
        n_next_exp  = r_next_exp;
        n_count     = r_count;
        n_clr       = r_clr;
        n_num       = r_num;
        n_j         = r_j;
        n_term      = r_term;
        n_x         = r_x;
        n_prime     = r_prime;
        n_index     = r_index;
        n_acc       = r_acc;
        n_st        = r_st;
        n_out_valid = r_out_valid && !o_out.ready;
        w_cm_we     = 1'b0;
        w_cm_waddr  = r_clr;
        w_cm_wdata  = 1'b0;
        w_pl_we     = 1'b0;
        w_div_start = 1'b0;
        w_div_a     = r_x;
        w_div_b     = r_num;
        unique case (r_state)
            S_CLEAR: begin
                w_cm_we = 1'b1;
                n_clr   = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_num   = i_in.number_in;
                    n_prime = 1'b0;
                    n_index = '0;
                    n_acc   = '0;
                    n_j     = '0;
                    n_st    = ST_OK;
                    if (i_in.number_in < NUM_W'(2) || i_in.number_in != r_next_exp) begin
                        n_st    = ST_SEQ_ERR;
                        n_state = S_DONE;
                    end else if (i_in.number_in > r_total_a
                                 || 32'(i_in.number_in) >= MAX_N) begin
                        n_st    = ST_ABOVE_A;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                // bitmap read issued at accept is valid now
                if (!w_cm_rdata) begin
                    n_prime = 1'b1;
                    n_index = IDX_W'(r_count);
                    if (r_count != CNT_FULL) begin
                        w_pl_we = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                n_next_exp = r_next_exp + 1'b1;
                n_state    = S_LIST_RD;
            end
            S_LIST_RD: begin
                n_state = (r_j < r_count) ? S_LIST_CHK : S_LIST_END;
            end
            S_LIST_CHK: begin
                // q > a/num  <=>  q*num > a
                if (w_pl_rdata < NUM_W'(2) || w_prod > {{NUM_W{1'b0}}, r_total_a}) begin
                    n_state = S_LIST_END;
                end else begin
                    w_cm_we     = 32'(w_prod) < MAX_N;
                    w_cm_waddr  = CW'(w_prod);
                    w_cm_wdata  = 1'b1;
                    w_div_start = 1'b1;
                    w_div_a     = r_num;
                    w_div_b     = w_pl_rdata;
                    n_state     = S_LIST_DIV;
                end
            end
            S_LIST_DIV: begin
                if (w_div_done) begin
                    if (w_rem == '0) begin
                        n_state = S_LIST_END;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_LIST_RD;
                    end
                end
            end
            S_LIST_END: begin
                n_term = 2'd0;
                n_x    = r_total_a;
                if (r_choose_b > r_total_a) begin
                    n_st    = ST_B_ABOVE;
                    n_state = S_DONE;
                end else if (!r_prime) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_LEG;
                end
            end
            S_LEG: begin
                // terms: L(a) added, L(b) and L(a-b) subtracted; mod 16 is enough
                if (r_x == '0) begin
                    n_term = r_term + 1'b1;
                    if (r_term == 2'd0) begin
                        n_x = r_choose_b;
                    end else begin
                        n_x = r_total_a - r_choose_b;
                    end
                    if (r_term == 2'd2) begin
                        n_state = S_DONE;
                    end
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_LEG_DIV;
                end
            end
            S_LEG_DIV: begin
                if (w_div_done) begin
                    n_x = w_quot;
                    if (r_term == 2'd0) begin
                        n_acc = r_acc + w_quot[EXP_W-1:0];
                    end else begin
                        n_acc = r_acc - w_quot[EXP_W-1:0];
                    end
                    n_state = S_LEG;
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_next_exp  <= NUM_W'(2);
            r_out_valid <= 1'b0;
            r_total_a   <= '0;
            r_choose_b  <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_next_exp  <= n_next_exp;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TOTAL_A:  r_total_a  <= i_cfg_data;
                    CFG_CHOOSE_B: r_choose_b <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_j     <= n_j;
        r_term  <= n_term;
        r_x     <= n_x;
        r_prime <= n_prime;
        r_index <= n_index;
        r_acc   <= n_acc;
        r_st    <= n_st;
        if (r_state == S_DONE) begin
            r_o_prime <= r_prime;
            r_o_index <= r_index;
            r_o_exp   <= r_acc;
            r_o_st    <= r_st;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.is_prime    = r_o_prime;
    assign o_out.prime_index = r_o_index;
    assign o_out.exponent    = r_o_exp;
    assign o_out.status      = r_o_st;

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !i_in.ready)
        else $error("request taken during bitmap clear");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("prime count beyond list depth");

    a_composite_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_o_prime |-> r_o_index == '0 && r_o_exp == '0)
        else $error("nonprime result carries index or exponent");

    a_err_no_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_o_st != ST_OK |-> r_o_exp == '0)
        else $error("exponent set on flagged result");

    a_done_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> !r_out_valid || o_out.ready)
        else $error("result register overwritten");
endmodule

/* verif/sieve_binomial_prime_exponents_unit_tb.sv */
// Self-checking testbench for sieve_binomial_prime_exponents_unit.
// Depends on sbpe_pkg, sbpe_in_if, sbpe_out_if and the unit itself.
`timescale 1ns / 1ps

module sieve_binomial_prime_exponents_unit_tb;
    import sbpe_pkg::*;

    localparam int SIEVE_N    = 4096;
    localparam int LIST_DEPTH = 1024;
    localparam int CYCLE_CAP  = 4000000;
    localparam int ITEM_GOAL  = 1380;

    typedef struct packed {
        logic             is_prime;
        logic [IDX_W-1:0] prime_index;
        logic [EXP_W-1:0] exponent;
        logic [ST_W-1:0]  status;
    } t_sieve_res;

    typedef enum logic [1:0] {ROW_CFG, ROW_CHECKED, ROW_TYPED} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [NUM_W-1:0] num;    // number, or total_a for a config row
        logic [NUM_W-1:0] b_val;  // choose_b for a config row
        t_sieve_res       res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_idx = CFG_TOTAL_A;
    logic [NUM_W-1:0] i_cfg_data = '0;

    sbpe_in_if  in_ch ();
    sbpe_out_if out_ch ();

    sieve_binomial_prime_exponents_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    bit               composite_seen [SIEVE_N];
    logic [NUM_W-1:0] prime_store [LIST_DEPTH];
    int               primes_stored;
    logic [NUM_W-1:0] next_number;
    logic [NUM_W-1:0] limit_a;
    logic [NUM_W-1:0] lower_b;

    t_sieve_res pending_results[$];
    int  failures = 0;
    int  requests_sent = 0;
    int  results_seen = 0;
    int  primes_seen = 0;
    int  status_hits [4] = '{0, 0, 0, 0};
    int  cycle_count = 0;
    bit  hold_active = 0;
    bit  list_filled = 0;

    function automatic int legendre_power(int x, int p);
        int s;
        s = 0;
        while (x != 0) begin
            x = x / p;
            s += x;
        end
        return s;
    endfunction

    // advances the sieve state and returns the result the unit should give
    function automatic t_sieve_res sieve_next(logic [NUM_W-1:0] num);
        t_sieve_res r;
        int q;
        int prod;
        r = '0;
        if (num < 2 || num != next_number) begin
            r.status = ST_SEQ_ERR;
        end else if (num > limit_a) begin
            r.status = ST_ABOVE_A;
        end else begin
            if (!composite_seen[num]) begin
                r.is_prime = 1'b1;
                r.prime_index = primes_stored[IDX_W-1:0];
                if (primes_stored < LIST_DEPTH) begin
                    prime_store[primes_stored] = num;
                    primes_stored++;
                end else begin
                    list_filled = 1;
                end
            end
            for (int j = 0; j < primes_stored; j++) begin
                q = int'(prime_store[j]);
                if (q < 2 || q > int'(limit_a) / int'(num)) break;
                prod = q * int'(num);
                if (prod < SIEVE_N) composite_seen[prod] = 1;
                if (int'(num) % q == 0) break;
            end
            if (lower_b > limit_a) begin
                r.status = ST_B_ABOVE;
            end else if (r.is_prime) begin
                r.exponent = EXP_W'(legendre_power(int'(limit_a), int'(num))
                           - legendre_power(int'(lower_b), int'(num))
                           - legendre_power(int'(limit_a) - int'(lower_b), int'(num)));
            end
            if (!r.is_prime) r.prime_index = '0;
            next_number = next_number + 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 results_seen, what, got, want);
        failures++;
    endtask

    // one long hold-off of the result side, counted here
    initial begin
        wait (results_seen >= 700);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    // results side: random stalls, the hold-off above, a calm window
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
        if (out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected", out_ch.status, -1);
            end else begin
                t_sieve_res w;
                w = pending_results.pop_front();
                if (out_ch.is_prime !== w.is_prime)
                    report_mismatch("is_prime", out_ch.is_prime, w.is_prime);
                if (out_ch.prime_index !== w.prime_index)
                    report_mismatch("prime_index", out_ch.prime_index, w.prime_index);
                if (out_ch.exponent !== w.exponent)
                    report_mismatch("exponent", out_ch.exponent, w.exponent);
                if (out_ch.status !== w.status)
                    report_mismatch("status", out_ch.status, w.status);
                if (w.is_prime) primes_seen++;
                status_hits[w.status]++;
            end
            results_seen++;
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_active) begin
            out_ch.ready <= 1'b0;
        end else if (results_seen >= 900 && results_seen < 1150) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= 19);
        end
    end

    task automatic send_number(logic [NUM_W-1:0] num, bit typed, t_sieve_res want);
        t_sieve_res got;
        bit calm;
        calm = (requests_sent >= 900 && requests_sent < 1150);
        while (!calm && $urandom_range(99) < 19) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.number_in <= num;
        do @(posedge i_clk); while (!in_ch.ready);
        got = sieve_next(num);
        pending_results.insert(pending_results.size(), typed ? want : got);
        requests_sent++;
    endtask

    task automatic set_config(logic [NUM_W-1:0] a, logic [NUM_W-1:0] b);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_TOTAL_A;
        i_cfg_data <= a;
        @(posedge i_clk);
        limit_a = a;
        i_cfg_idx <= CFG_CHOOSE_B;
        i_cfg_data <= b;
        @(posedge i_clk);
        lower_b = b;
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_row cfg_row(int a, int b);
        t_row r;
        r.kind = ROW_CFG; r.num = NUM_W'(a); r.b_val = NUM_W'(b); r.res = '0;
        return r;
    endfunction

    function automatic t_row num_row(int n);
        t_row r;
        r.kind = ROW_CHECKED; r.num = NUM_W'(n); r.b_val = '0; r.res = '0;
        return r;
    endfunction

    function automatic t_row typed_row(int n, bit p, int idx, int e, logic [ST_W-1:0] st);
        t_row r;
        r.kind = ROW_TYPED; r.num = NUM_W'(n); r.b_val = '0;
        r.res.is_prime = p; r.res.prime_index = IDX_W'(idx);
        r.res.exponent = EXP_W'(e); r.res.status = st;
        return r;
    endfunction

    initial begin
        t_row table_rows[$];
        t_row row;
        int stop_at;
        int a_pick;
        int b_pick;

        in_ch.valid = 1'b0;
        in_ch.number_in = '0;
        for (int k = 0; k < SIEVE_N; k++) composite_seen[k] = 0;
        primes_stored = 0;
        next_number = 2;
        limit_a = '0;
        lower_b = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every status, b equal to a, b above a
        table_rows = '{
            cfg_row(0, 0),
            typed_row(2, 0, 0, 0, ST_ABOVE_A),
            typed_row(0, 0, 0, 0, ST_SEQ_ERR),
            typed_row(1, 0, 0, 0, ST_SEQ_ERR),
            typed_row(4095, 0, 0, 0, ST_SEQ_ERR),
            typed_row(3, 0, 0, 0, ST_SEQ_ERR),
            cfg_row(4095, 4095),
            typed_row(2, 1, 0, 0, ST_OK),
            typed_row(3, 1, 1, 0, ST_OK),
            typed_row(4, 0, 0, 0, ST_OK),
            cfg_row(4095, 2048),
            num_row(5), num_row(6), num_row(7),
            cfg_row(10, 11),
            typed_row(8, 0, 0, 0, ST_B_ABOVE),
            num_row(9), num_row(10),
            typed_row(11, 0, 0, 0, ST_ABOVE_A),
            cfg_row(4095, 0),
            num_row(11), num_row(12), num_row(13)
        };
        foreach (table_rows[k]) begin
            row = table_rows[k];
            if (row.kind == ROW_CFG) set_config(row.num, row.b_val);
            else send_number(row.num, row.kind == ROW_TYPED, row.res);
        end

        // random: in-order chunks with noise; narrow limits leave most later
        // composites unmarked, so the prime list fills up
        while (next_number != 0 && requests_sent < ITEM_GOAL) begin
            a_pick = int'(next_number) + $urandom_range(20, 80);
            if (a_pick > 4095) a_pick = 4095;
            stop_at = a_pick;
            case ($urandom_range(3))
                0: b_pick = 0;
                1: b_pick = a_pick;
                2: b_pick = $urandom_range(a_pick);
                default: b_pick = (a_pick < 4095) ? $urandom_range(4095, a_pick + 1)
                                                  : $urandom_range(4095);
            endcase
            set_config(NUM_W'(a_pick), NUM_W'(b_pick));
            while (next_number != 0 && next_number <= stop_at
                   && requests_sent < ITEM_GOAL) begin
                if ($urandom_range(99) < 8)
                    send_number(NUM_W'($urandom_range(4095)), 1'b0, '0);
                else
                    send_number(next_number, 1'b0, '0);
            end
            if (next_number != 0 && next_number > a_pick)
                send_number(next_number, 1'b0, '0);
        end
        // a burst of numbers that are mostly out of order
        for (int k = 0; k < 20; k++) send_number(NUM_W'($urandom_range(4095)), 1'b0, '0);
        send_number(NUM_W'(0), 1'b0, '0);
        send_number(NUM_W'(2), 1'b0, '0);

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sieved up to %0d under moving limits with noise: %0d requests,",
                 next_number, requests_sent);
        $display("%0d primes reported, list full reached %0d, status counts %0d/%0d/%0d/%0d",
                 primes_seen, list_filled, status_hits[0], status_hits[1],
                 status_hits[2], status_hits[3]);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
